// ===== design/websocket_frame_deframer_top_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication.
`define WSD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define WSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/wsd_pkg.sv =====
// Shared types and constants for the websocket frame deframer.
// No dependencies; used by wsd_parser and websocket_frame_deframer_top.
`default_nettype none

package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  localparam logic [6:0] LEN7_EXT16  = 7'd126;
  localparam logic [6:0] LEN7_EXT64  = 7'd127;
  localparam logic [2:0] EXT16_BYTES = 3'd2;
  localparam logic [2:0] KEY_BYTES   = 3'd4;
  localparam logic [2:0] EXT64_LAST  = 3'd7;

  typedef struct packed {
    logic       fin;
    logic [3:0] opcode;
    logic       last;
    logic       valid;
    logic [7:0] data;
  } result_t;

endpackage

`default_nettype wire

// ===== design/websocket_frame_deframer_top.sv =====
// Websocket frame deframer top level: input register, parser, result register.
// Depends on wsd_pkg, wsd_parser and websocket_frame_deframer_top_macros.svh.
//
// Usage:
//   The slave channel takes the raw frame stream, one byte per transaction
//   on s_tdata. Frames follow each other with no gap: header, extended
//   length, masking key, payload.
//   The master channel gives one transaction per payload byte, unmasked,
//   with m_tlast on the last byte of the frame. A frame with an empty
//   payload gives a single marker transaction (m_tuser[0] low, m_tlast high,
//   data byte zero) on the byte that completes its header.
//   Header bytes otherwise give no transaction.
//   A payload byte goes from the input register through the parser into
//   the result register, from which it is presented on the master channel.
//   Throughput: one byte per cycle while the receiver takes results, set by
//   the parser update between the input register and the result register.
//   Reset (rst, synchronous) empties both registers and returns the parser
//   to the first header byte.
//   When the receiver stalls, the result register holds; the input register
//   takes one more byte and then s_tready drops until the result is taken.
`default_nettype none

module websocket_frame_deframer_top #(
  parameter int LENGTH_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] payload_byte, [11:8] frame_opcode, [15:12] zero
  output logic        m_tlast,   // last_of_frame
  output logic [1:0]  m_tuser    // [0] payload_valid, [1] final_fragment
);

  `include "websocket_frame_deframer_top_macros.svh"

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             advance;
  logic             has_result;
  wsd_pkg::result_t result;
  wsd_pkg::result_t out_reg;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  wsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .data_byte  (in_byte),
    .has_result (has_result),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= has_result;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {4'b0000, out_reg.opcode, out_reg.data};
  assign m_tlast = out_reg.last;
  assign m_tuser = {out_reg.fin, out_reg.valid};

  `WSD_ASSERT_IMPL(a_marker_shape, m_tvalid && !m_tuser[0], m_tlast && m_tdata[7:0] == 8'd0)
  `WSD_ASSERT_NEXT(a_input_hold, in_valid && !advance, in_valid && $stable(in_byte))
  `WSD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(out_reg))

endmodule

`default_nettype wire

// ===== design/wsd_parser.sv =====
// Frame header parser and payload unmasker: one byte per enable.
// Depends on wsd_pkg.
`default_nettype none

module wsd_parser #(
  parameter int LENGTH_BITS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [7:0]       data_byte,
  output logic             has_result,
  output wsd_pkg::result_t result
);

  wsd_pkg::phase_t         phase, phase_next;
  logic [2:0]              hdr_count, hdr_count_next;
  logic [LENGTH_BITS-1:0]  remaining, remaining_next;
  logic [31:0]             key, key_next;
  logic                    masked, masked_next;
  logic                    fin, fin_next;
  logic [3:0]              opcode, opcode_next;
  logic [1:0]              key_index, key_index_next;

  logic [6:0]              len7;
  logic [LENGTH_BITS-1:0]  shifted;
  logic [LENGTH_BITS-1:0]  rem_dec;
  logic [7:0]              key_byte;

  assign len7     = data_byte[6:0];
  assign shifted  = {remaining[LENGTH_BITS-9:0], data_byte};
  assign rem_dec  = remaining - LENGTH_BITS'(1);

  always_comb begin
    unique case (key_index)
      2'd0:    key_byte = key[31:24];
      2'd1:    key_byte = key[23:16];
      2'd2:    key_byte = key[15:8];
      default: key_byte = key[7:0];
    endcase
  end

  // Next state and header registers.
  always_comb begin
    phase_next     = phase;
    hdr_count_next = hdr_count;
    remaining_next = remaining;
    key_next       = key;
    masked_next    = masked;
    fin_next       = fin;
    opcode_next    = opcode;
    key_index_next = key_index;
    unique case (phase)
      wsd_pkg::PH_HDR1: begin
        masked_next    = data_byte[7];
        key_next       = '0;
        hdr_count_next = '0;
        remaining_next = LENGTH_BITS'(len7);
        key_index_next = '0;
        if (len7 == wsd_pkg::LEN7_EXT16) begin
          phase_next     = wsd_pkg::PH_EXT16;
          remaining_next = '0;
        end else if (len7 == wsd_pkg::LEN7_EXT64) begin
          phase_next     = wsd_pkg::PH_EXT64;
          remaining_next = '0;
        end else if (data_byte[7]) begin
          phase_next = wsd_pkg::PH_KEY;
        end else if (len7 == 7'd0) begin
          phase_next = wsd_pkg::PH_HDR0;
        end else begin
          phase_next = wsd_pkg::PH_DATA;
        end
      end
      wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
        remaining_next = shifted;
        hdr_count_next = hdr_count + 3'd1;
        if ((phase == wsd_pkg::PH_EXT16 && hdr_count + 3'd1 == wsd_pkg::EXT16_BYTES) ||
            (phase == wsd_pkg::PH_EXT64 && hdr_count == wsd_pkg::EXT64_LAST)) begin
          hdr_count_next = '0;
          key_index_next = '0;
          if (masked) begin
            phase_next = wsd_pkg::PH_KEY;
          end else if (shifted == '0) begin
            phase_next = wsd_pkg::PH_HDR0;
          end else begin
            phase_next = wsd_pkg::PH_DATA;
          end
        end
      end
      wsd_pkg::PH_KEY: begin
        key_next       = {key[23:0], data_byte};
        hdr_count_next = hdr_count + 3'd1;
        if (hdr_count + 3'd1 == wsd_pkg::KEY_BYTES) begin
          hdr_count_next = '0;
          key_index_next = '0;
          phase_next     = (remaining == '0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_DATA;
        end
      end
      wsd_pkg::PH_DATA: begin
        key_index_next = key_index + 2'd1;
        remaining_next = rem_dec;
        if (rem_dec == '0) begin
          phase_next = wsd_pkg::PH_HDR0;
        end
      end
      default: begin
        fin_next    = data_byte[7];
        opcode_next = data_byte[3:0];
        phase_next  = wsd_pkg::PH_HDR1;
      end
    endcase
  end

  // Result for the current byte.
  always_comb begin
    has_result    = 1'b0;
    result.fin    = fin;
    result.opcode = opcode;
    result.last   = 1'b1;
    result.valid  = 1'b0;
    result.data   = '0;
    unique case (phase)
      wsd_pkg::PH_HDR1: begin
        has_result = !data_byte[7] && len7 == 7'd0;
      end
      wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
        has_result = !masked && shifted == '0 &&
          ((phase == wsd_pkg::PH_EXT16 && hdr_count + 3'd1 == wsd_pkg::EXT16_BYTES) ||
           (phase == wsd_pkg::PH_EXT64 && hdr_count == wsd_pkg::EXT64_LAST));
      end
      wsd_pkg::PH_KEY: begin
        has_result = hdr_count + 3'd1 == wsd_pkg::KEY_BYTES && remaining == '0;
      end
      wsd_pkg::PH_DATA: begin
        has_result   = 1'b1;
        result.valid = 1'b1;
        result.last  = rem_dec == '0;
        result.data  = masked ? (data_byte ^ key_byte) : data_byte;
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= wsd_pkg::PH_HDR0;
      hdr_count <= '0;
      remaining <= '0;
      key       <= '0;
      masked    <= 1'b0;
      fin       <= 1'b0;
      opcode    <= '0;
      key_index <= '0;
    end else if (en) begin
      phase     <= phase_next;
      hdr_count <= hdr_count_next;
      remaining <= remaining_next;
      key       <= key_next;
      masked    <= masked_next;
      fin       <= fin_next;
      opcode    <= opcode_next;
      key_index <= key_index_next;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for websocket_frame_deframer_top: streams framed bytes
// and checks every payload and empty-frame transaction against a local deframer.
// Depends on wsd_pkg and the deframer RTL.
module tb;

  localparam int LEN_BITS = 64;
  localparam int RANDOM_BYTES = 850;
  localparam int HOLD_AT = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT = 400000;

  typedef enum logic [1:0] {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic m_tlast;
  logic [1:0] m_tuser;

  websocket_frame_deframer_top #(
    .LENGTH_BITS(LEN_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [7:0] stream_q[$];
  wsd_pkg::result_t payload_due[$];
  wsd_pkg::result_t want;
  int queued = 0;
  int bytes_in = 0;
  int mismatches = 0;
  int cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit byte_taken = 1'b0;
  bit steady = 1'b0;

  wsd_pkg::phase_t ph = wsd_pkg::PH_HDR0;
  logic [2:0] hdr_cnt = '0;
  logic [LEN_BITS-1:0] remaining = '0;
  logic [31:0] mkey = '0;
  logic masked = 1'b0;
  logic fin_h = 1'b0;
  logic [3:0] opc_h = '0;
  logic [1:0] kidx = '0;

  function automatic logic header_complete();
    kidx = '0;
    hdr_cnt = '0;
    if (remaining == '0) begin
      ph = wsd_pkg::PH_HDR0;
      return 1'b1;
    end
    ph = wsd_pkg::PH_DATA;
    return 1'b0;
  endfunction

  function automatic logic length_complete();
    hdr_cnt = '0;
    if (masked) begin
      ph = wsd_pkg::PH_KEY;
      return 1'b0;
    end
    return header_complete();
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    wsd_pkg::result_t r;
    logic emit;
    r = '0;
    emit = 1'b0;
    r.fin = fin_h;
    r.opcode = opc_h;
    r.last = 1'b1;
    case (ph)
      wsd_pkg::PH_HDR1: begin
        masked = b[7];
        mkey = '0;
        hdr_cnt = '0;
        remaining = '0;
        if (b[6:0] == wsd_pkg::LEN7_EXT16) begin
          ph = wsd_pkg::PH_EXT16;
        end else if (b[6:0] == wsd_pkg::LEN7_EXT64) begin
          ph = wsd_pkg::PH_EXT64;
        end else begin
          remaining = LEN_BITS'(b[6:0]);
          emit = length_complete();
        end
      end
      wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
        remaining = {remaining[LEN_BITS-9:0], b};
        hdr_cnt = hdr_cnt + 3'd1;
        if ((ph == wsd_pkg::PH_EXT16 && hdr_cnt == wsd_pkg::EXT16_BYTES) ||
            (ph == wsd_pkg::PH_EXT64 && hdr_cnt == '0))
          emit = length_complete();
      end
      wsd_pkg::PH_KEY: begin
        mkey = {mkey[23:0], b};
        hdr_cnt = hdr_cnt + 3'd1;
        if (hdr_cnt == wsd_pkg::KEY_BYTES) emit = header_complete();
      end
      wsd_pkg::PH_DATA: begin
        r.data = masked ? (b ^ mkey[8*(3-kidx) +: 8]) : b;
        r.valid = 1'b1;
        kidx = kidx + 2'd1;
        remaining = remaining - LEN_BITS'(1);
        r.last = (remaining == '0);
        if (r.last) ph = wsd_pkg::PH_HDR0;
        emit = 1'b1;
      end
      default: begin
        fin_h = b[7];
        opc_h = b[3:0];
        ph = wsd_pkg::PH_HDR1;
      end
    endcase
    if (emit) payload_due.push_back(r);
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    stream_q.push_back(b);
    queued++;
  endfunction

  function automatic void push_seq(input logic [63:0] value, input int n);
    for (int i = n - 1; i >= 0; i--) put_byte(value[8*i +: 8]);
  endfunction

  function automatic void queue_frame(input logic [7:0] head, input logic mask,
                                      input len_form_t form, input logic [63:0] len,
                                      input int n_payload);
    put_byte(head);
    case (form)
      LEN_SHORT: put_byte({mask, len[6:0]});
      LEN_EXT16: begin
        put_byte({mask, wsd_pkg::LEN7_EXT16});
        push_seq(len, 2);
      end
      default: begin
        put_byte({mask, wsd_pkg::LEN7_EXT64});
        push_seq(len, 8);
      end
    endcase
    if (mask) push_seq({32'h0, $urandom}, 4);
    repeat (n_payload) put_byte(8'($urandom));
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got);
    if (got !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got);
      mismatches++;
    end
  endtask

  task automatic wait_drained();
    while (stream_q.size() != 0 || s_tvalid || payload_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) steady <= ~steady;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      byte_taken = 1'b0;
      if (!rst) begin
        if (s_tvalid && s_tready) begin
          deframe_byte(s_tdata);
          bytes_in++;
          byte_taken = 1'b1;
        end
        if (m_tvalid && m_tready) begin
          if (payload_due.size() == 0) begin
            $error("unexpected transaction: tdata %h tuser %b tlast %b",
                   m_tdata, m_tuser, m_tlast);
            mismatches++;
          end else begin
            want = payload_due.pop_front();
            check_field("payload_byte", want.data, m_tdata[7:0]);
            check_field("payload_valid", 8'(want.valid), 8'(m_tuser[0]));
            check_field("last_of_frame", 8'(want.last), 8'(m_tlast));
            check_field("frame_opcode", 8'(want.opcode), 8'(m_tdata[11:8]));
            check_field("final_fragment", 8'(want.fin), 8'(m_tuser[1]));
            check_field("tdata_pad", 8'h00, 8'(m_tdata[15:12]));
          end
        end
      end
    end
  end

  // hold the current byte until taken, then advance after an optional gap
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || byte_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (stream_q.size() != 0) begin
        s_tdata <= stream_q.pop_front();
        s_tvalid <= 1'b1;
        gap_left = idle_len();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!hold_done && bytes_in >= HOLD_AT) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      stall_left = idle_len();
    end
  end

  initial begin
    int r;
    int start;
    bit paused;
    len_form_t form;
    logic [63:0] len;
    paused = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_seq(64'h0000, 2);
    push_seq(64'hFF80_FFFF_FFFF, 6);
    push_seq(64'h81_7E00_01FF, 5);
    push_seq(64'h82FF, 2);
    push_seq(64'h2, 8);
    push_seq(64'h1234_5678_00FF, 6);
    wait_drained();

    start = queued;
    while (queued - start < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      form = (r < 70) ? LEN_SHORT : ((r < 90) ? LEN_EXT16 : LEN_EXT64);
      r = $urandom_range(0, 99);
      if (r < 10) len = '0;
      else if (r < 80) len = 64'($urandom_range(1, 8));
      else if (r < 96) len = 64'($urandom_range(9, 40));
      else len = 64'($urandom_range(41, 125));
      if (form == LEN_EXT16 && $urandom_range(0, 9) == 0) len = 64'($urandom_range(126, 400));
      queue_frame(8'($urandom), 1'($urandom), form, len, int'(len));
      if (!paused && queued - start >= RANDOM_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    // cut the run short inside a frame whose 64-bit length has its top bit set
    queue_frame(8'($urandom), 1'($urandom), LEN_EXT64, 64'h8000_0000_0000_0005, 30);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
